// ===== rtl/core/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
package rau_pkg;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_SUB  = 2'd1,
    OP_MUL  = 2'd2,
    OP_NORM = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_ZDEN = 2'd2
  } status_e;

  // Handshake between the sequencer and the shared iterative unit.
  typedef struct packed {
    logic start;
    logic is_mul;
  } unit_req_t;

endpackage

// ===== rtl/core/rau_iter_unit.sv =====
// Shared iterative unit: shift-add multiplier and restoring divider.
module rau_iter_unit #(
  parameter int unsigned DW = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rau_pkg::unit_req_t   req_i,
  input  logic [DW-1:0]        x_i,
  input  logic [DW-1:0]        y_i,
  output logic                 done_o,
  output logic [DW-1:0]        quo_o,
  output logic [DW-1:0]        rem_o
);
  import rau_pkg::*;

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, busy_d, mul_q, mul_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] acc_q, acc_d, sh_q, sh_d, y_q, y_d;
  logic [DW:0]   trial;

  // For multiply: acc accumulates, sh shifts right the multiplier, y shifts left.
  // For divide: acc is the partial remainder, sh shifts the dividend into quotient.
  assign trial = {acc_q, sh_q[DW-1]} - {1'b0, y_q};

  always_comb begin
    busy_d = busy_q;
    mul_d  = mul_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    sh_d   = sh_q;
    y_d    = y_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      mul_d  = req_i.is_mul;
      cnt_d  = CW'(DW);
      acc_d  = '0;
      sh_d   = x_i;
      y_d    = y_i;
    end else if (busy_q) begin
      if (mul_q) begin
        if (sh_q[0]) acc_d = acc_q + y_q;
        sh_d = sh_q >> 1;
        y_d  = y_q << 1;
      end else begin
        if (!trial[DW]) begin
          acc_d = trial[DW-1:0];
          sh_d  = {sh_q[DW-2:0], 1'b1};
        end else begin
          acc_d = {acc_q[DW-2:0], sh_q[DW-1]};
          sh_d  = {sh_q[DW-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      mul_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      mul_q  <= mul_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    y_q   <= y_d;
  end

  assign done_o = busy_q && (cnt_q == CW'(1));
  assign quo_o  = mul_q ? acc_d : sh_d;
  assign rem_o  = acc_d;
endmodule

// ===== rtl/core/rational_arith_unit.sv =====
// Top level of the rational arithmetic unit: sequencer around the shared unit.
//
// One transfer is taken when start_i is high and busy_o is low; busy_o then
// stays high until the result is shown on res_num_o, res_den_o and status_o
// for exactly one cycle with valid_o high, and the next item may be started in
// that same cycle. Every multiply and every division runs on one shared
// shift-add / restoring-divide unit of 2*WIDTH bits. Add and subtract use three
// multiplies, multiply two, normalize none; the Euclidean gcd takes one
// division per step, typically a handful of steps and at most about
// 1.44 * 2*WIDTH steps, followed by two divisions to reduce. A zero denominator
// is reported without using the shared unit. The receiver cannot stall.
module rational_arith_unit #(
  parameter int unsigned WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] a_num_i,
  input  logic [31:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [31:0] b_den_i,
  output logic        valid_o,
  output logic [31:0] res_num_o,
  output logic [30:0] res_den_o,
  output logic [1:0]  status_o
);
  import rau_pkg::*;

  localparam int unsigned DW = 2 * WIDTH;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_CHECK = 11'b00000000010,
    S_M1    = 11'b00000000100,
    S_M2    = 11'b00000001000,
    S_M3    = 11'b00000010000,
    S_COMB  = 11'b00000100000,
    S_GCD   = 11'b00001000000,
    S_DIVN  = 11'b00010000000,
    S_DIVD  = 11'b00100000000,
    S_FIN   = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic   wait_q, wait_d;

  // Operand magnitudes and signs, held through the item.
  logic [WIDTH-1:0] an_q, ad_q, bn_q, bd_q;
  logic             sa_q, sb_q;
  op_e              op_q;
  logic [DW-1:0]    p_q, p_d, q_q, q_d, rd_q, rd_d, rn_q, rn_d;
  logic [DW-1:0]    gx_q, gx_d, gy_q, gy_d;
  logic             rs_q, rs_d;
  logic [31:0]      onum_q, onum_d;
  logic [30:0]      oden_q, oden_d;
  logic [1:0]       ost_q, ost_d;

  unit_req_t        req;
  logic [DW-1:0]    ux, uy, uquo, urem;
  logic             udone;

  // The gcd loop issues a new division whenever the unit is idle.
  logic             ubusy_q;

  function automatic logic [WIDTH-1:0] mag(input logic [31:0] v);
    logic [WIDTH-1:0] w;
    w = v[WIDTH-1:0];
    return w[WIDTH-1] ? (~w + 1'b1) : w;
  endfunction

  rau_iter_unit #(.DW(DW)) u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .x_i    (ux),
    .y_i    (uy),
    .done_o (udone),
    .quo_o  (uquo),
    .rem_o  (urem)
  );

  logic          sq;
  logic [DW-1:0] lim;
  assign sq  = (op_q == OP_SUB) ? !sb_q : sb_q;
  assign lim = DW'(1) << (WIDTH - 1);

  always_comb begin
    state_d = state_q;
    wait_d  = wait_q;
    p_d = p_q; q_d = q_q; rd_d = rd_q; rn_d = rn_q;
    gx_d = gx_q; gy_d = gy_q; rs_d = rs_q;
    onum_d = onum_q; oden_d = oden_q; ost_d = ost_q;
    req = '0;
    ux  = '0;
    uy  = '0;
    case (state_q)
      S_IDLE, S_OUT: begin
        // The result is shown for one cycle only; a new transfer clears the
        // gcd registers.
        state_d = S_IDLE;
        if (start_i) begin
          gx_d = '0; gy_d = '0; state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        wait_d = 1'b0;
        if (ad_q == '0 || (op_q != OP_NORM && bd_q == '0)) begin
          onum_d = '0; oden_d = '0; ost_d = ST_ZDEN; state_d = S_OUT;
        end else if (op_q == OP_NORM) begin
          rs_d = sa_q; rn_d = DW'(an_q); rd_d = DW'(ad_q); state_d = S_COMB;
        end else begin
          state_d = S_M1;
        end
      end
      S_M1, S_M2, S_M3: begin
        req.is_mul = 1'b1;
        if (state_q == S_M1) begin
          ux = DW'(ad_q); uy = DW'(bd_q);
        end else if (state_q == S_M2) begin
          ux = DW'(an_q); uy = DW'(bn_q);
          if (op_q != OP_MUL) uy = DW'(bd_q);
        end else begin
          ux = DW'(bn_q); uy = DW'(ad_q);
        end
        if (!wait_q) begin
          req.start = 1'b1; wait_d = 1'b1;
        end else if (udone) begin
          wait_d = 1'b0;
          if (state_q == S_M1) begin
            rd_d = uquo; state_d = S_M2;
          end else if (state_q == S_M2) begin
            p_d = uquo;
            if (op_q == OP_MUL) begin
              rn_d = uquo; rs_d = sa_q ^ sb_q; state_d = S_COMB;
            end else begin
              state_d = S_M3;
            end
          end else begin
            q_d = uquo; state_d = S_COMB;
            if (op_q == OP_MUL) state_d = S_COMB;
          end
        end
      end
      S_COMB: begin
        if (op_q == OP_ADD || op_q == OP_SUB) begin
          if (sa_q == sq) begin
            rs_d = sa_q; rn_d = p_q + q_q;
          end else if (p_q >= q_q) begin
            rs_d = sa_q; rn_d = p_q - q_q;
          end else begin
            rs_d = sq; rn_d = q_q - p_q;
          end
        end
        state_d = S_GCD;
      end
      S_GCD: begin
        if (rn_q == '0) begin
          onum_d = '0; oden_d = 31'd1; ost_d = ST_OK; state_d = S_OUT;
        end else if (!wait_q && gx_q == '0 && gy_q == '0) begin
          gx_d = rn_q; gy_d = rd_q; wait_d = 1'b1;
        end else if (gy_q == '0) begin
          wait_d = 1'b0; state_d = S_DIVN;
        end else begin
          ux = gx_q; uy = gy_q;
          if (wait_q && !ubusy_q) req.start = 1'b1;
          if (udone) begin
            gx_d = gy_q; gy_d = urem;
          end
        end
      end
      S_DIVN, S_DIVD: begin
        ux = (state_q == S_DIVN) ? rn_q : rd_q;
        uy = gx_q;
        if (!wait_q) begin
          req.start = 1'b1; wait_d = 1'b1;
        end else if (udone) begin
          wait_d = 1'b0;
          if (state_q == S_DIVN) begin
            rn_d = uquo; state_d = S_DIVD;
          end else begin
            rd_d = uquo; state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        gx_d = '0; gy_d = '0;
        if (rd_q > lim - 1'b1 || (rs_q ? rn_q > lim : rn_q > lim - 1'b1)) begin
          onum_d = '0; oden_d = '0; ost_d = ST_OVF;
        end else begin
          onum_d = 32'(rs_q ? (DW'(0) - rn_q) : rn_q);
          oden_d = 31'(rd_q);
          ost_d  = ST_OK;
        end
        state_d = S_OUT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ubusy_q <= 1'b0;
    end else if (req.start) begin
      ubusy_q <= 1'b1;
    end else if (udone) begin
      ubusy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wait_q  <= 1'b0;
      gx_q    <= '0;
      gy_q    <= '0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      gx_q    <= gx_d;
      gy_q    <= gy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      op_q <= op_e'(opcode_i);
      an_q <= mag(a_num_i);
      ad_q <= mag(a_den_i);
      bn_q <= mag(b_num_i);
      bd_q <= mag(b_den_i);
      sa_q <= a_num_i[WIDTH-1] ^ a_den_i[WIDTH-1];
      sb_q <= b_num_i[WIDTH-1] ^ b_den_i[WIDTH-1];
    end
    p_q <= p_d; q_q <= q_d; rd_q <= rd_d; rn_q <= rn_d; rs_q <= rs_d;
    onum_q <= onum_d; oden_q <= oden_d; ost_q <= ost_d;
  end

  assign busy_o    = !(state_q == S_IDLE || state_q == S_OUT);
  assign valid_o   = (state_q == S_OUT);
  assign res_num_o = onum_q;
  assign res_den_o = oden_q;
  assign status_o  = ost_q;

  // A result is shown only while the block is not busy.
  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy_o) else $error("result shown while busy");

  // An accepted item always makes the block busy next cycle.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start not taken");

  // A zero denominator report carries zero payload.
  a_zden: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o == ST_ZDEN) |-> (res_num_o == '0 && res_den_o == '0))
    else $error("zero denominator payload");
endmodule

// ===== tb/rau_checker.sv =====
// Result checker for the rational arithmetic unit: predicts each result and compares.
`timescale 1ns / 100ps

module rau_checker #(
  parameter int unsigned WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] a_num_i,
  input  logic [31:0] a_den_i,
  input  logic [31:0] b_num_i,
  input  logic [31:0] b_den_i,
  input  logic        valid_i,
  input  logic [31:0] res_num_i,
  input  logic [30:0] res_den_i,
  input  logic [1:0]  status_i,
  output int          errors_o,
  output int          pending_o,
  output int          n_ok_o,
  output int          n_ovf_o,
  output int          n_zden_o
);
  import rau_pkg::*;

  typedef struct {
    logic [31:0] num;
    logic [30:0] den;
    status_e     st;
  } fraction_t;

  fraction_t reduced_q[$];

  // Sign and magnitude of the low WIDTH bits of a field.
  function automatic void to_sign_mag(input logic [31:0] raw, output bit neg,
                                      output logic [63:0] mag);
    logic [63:0] v;
    v = 64'(raw) & ((64'd1 << WIDTH) - 64'd1);
    neg = v[WIDTH-1];
    mag = neg ? ((64'd1 << WIDTH) - v) : v;
  endfunction

  function automatic fraction_t reduce_fraction(op_e op, logic [31:0] an_raw,
      logic [31:0] ad_raw, logic [31:0] bn_raw, logic [31:0] bd_raw);
    fraction_t r;
    bit an_s, ad_s, bn_s, bd_s, sa, sb, sq, rs;
    logic [63:0] an, ad, bn, bd, p, q, rn, rd, x, y, t, lim;
    to_sign_mag(an_raw, an_s, an);
    to_sign_mag(ad_raw, ad_s, ad);
    to_sign_mag(bn_raw, bn_s, bn);
    to_sign_mag(bd_raw, bd_s, bd);
    r.num = '0;
    r.den = '0;
    r.st  = ST_ZDEN;
    if (ad == 0 || (op != OP_NORM && bd == 0)) return r;
    sa = an_s ^ ad_s;
    sb = bn_s ^ bd_s;
    case (op)
      OP_NORM: begin
        rs = sa; rn = an; rd = ad;
      end
      OP_MUL: begin
        rs = sa ^ sb; rn = an * bn; rd = ad * bd;
      end
      default: begin
        p  = an * bd;
        q  = bn * ad;
        sq = (op == OP_SUB) ? !sb : sb;
        rd = ad * bd;
        if (sa == sq) begin
          rs = sa; rn = p + q;
        end else if (p >= q) begin
          rs = sa; rn = p - q;
        end else begin
          rs = sq; rn = q - p;
        end
      end
    endcase
    r.st = ST_OK;
    if (rn == 0) begin
      r.den = 31'd1;
      return r;
    end
    // Euclid on the unreduced numerator and denominator.
    x = rn;
    y = rd;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    rn = rn / x;
    rd = rd / x;
    lim = 64'd1 << (WIDTH - 1);
    if (rd > lim - 1 || (rs ? rn > lim : rn > lim - 1)) begin
      r.st = ST_OVF;
      return r;
    end
    r.num = rs ? 32'(64'd0 - rn) : rn[31:0];
    r.den = rd[30:0];
    return r;
  endfunction

  assign pending_o = reduced_q.size();

  always @(posedge clk_i) begin
    fraction_t exp_r;
    if (rst_ni) begin
      if (start_i && !busy_i)
        reduced_q.push_back(reduce_fraction(op_e'(opcode_i), a_num_i, a_den_i,
                                            b_num_i, b_den_i));
      if (valid_i) begin
        if (reduced_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10)
            $display("%0t: unexpected result num=%0d den=%0d status=%0d",
                     $realtime, $signed(res_num_i), res_den_i, status_i);
        end else begin
          exp_r = reduced_q.pop_front();
          case (exp_r.st)
            ST_OK:   n_ok_o++;
            ST_OVF:  n_ovf_o++;
            default: n_zden_o++;
          endcase
          if (res_num_i !== exp_r.num || res_den_i !== exp_r.den ||
              status_i !== exp_r.st) begin
            errors_o++;
            if (errors_o <= 10)
              $display("%0t: mismatch expected %0d/%0d status %0d, got %0d/%0d status %0d",
                       $realtime, $signed(exp_r.num), exp_r.den, exp_r.st,
                       $signed(res_num_i), res_den_i, status_i);
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the rational arithmetic unit: stimulus, timeout and verdict.
`timescale 1ns / 100ps

module tb_top;
  import rau_pkg::*;

  localparam int unsigned WIDTH = 32;
  localparam int unsigned N_RANDOM = 1430;
  // A worst-case item runs long gcd chains on the shared divider; the limit is
  // on the total cycle count of the whole run.
  localparam longint unsigned CYCLE_LIMIT = 64'd40_000_000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [1:0]  opcode_i = OP_ADD;
  logic [31:0] a_num_i = '0;
  logic [31:0] a_den_i = '0;
  logic [31:0] b_num_i = '0;
  logic [31:0] b_den_i = '0;
  logic        busy_o;
  logic        valid_o;
  logic [31:0] res_num_o;
  logic [30:0] res_den_o;
  logic [1:0]  status_o;

  int errors, pending, n_ok, n_ovf, n_zden;
  int n_sent = 0;
  longint unsigned cycles = 0;

  rational_arith_unit #(.WIDTH(WIDTH)) u_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .opcode_i, .a_num_i, .a_den_i,
    .b_num_i, .b_den_i, .valid_o, .res_num_o, .res_den_o, .status_o
  );

  rau_checker #(.WIDTH(WIDTH)) u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .opcode_i, .a_num_i, .a_den_i,
    .b_num_i, .b_den_i, .valid_i(valid_o), .res_num_i(res_num_o),
    .res_den_i(res_den_o), .status_i(status_o), .errors_o(errors),
    .pending_o(pending), .n_ok_o(n_ok), .n_ovf_o(n_ovf), .n_zden_o(n_zden)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop if the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Present one item and hold it until the block takes the transfer.
  task automatic send_item(op_e op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
    @(negedge clk_i);
    opcode_i <= op;
    a_num_i  <= an;
    a_den_i  <= ad;
    b_num_i  <= bn;
    b_den_i  <= bd;
    start_i  <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    n_sent++;
  endtask

  // Drop start for a random burst of cycles.
  task automatic idle_burst();
    @(negedge clk_i);
    start_i <= 1'b0;
    repeat ($urandom_range(14, 0)) @(negedge clk_i);
  endtask

  // Mostly small magnitudes so reductions and zero denominators happen often;
  // the rest are full-width patterns and the signed extremes.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(9, 0))
      0, 1, 2, 3: return 32'($signed($urandom_range(200, 0)) - 100);
      4, 5:       return 32'($signed($urandom_range(131071, 0)) - 65536);
      6:          return 32'($urandom_range(2, 0) * 12 * $urandom_range(4096, 1));
      7:          begin
        case ($urandom_range(4, 0))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          3:       return 32'h0000_0001;
          default: return 32'hffff_ffff;
        endcase
      end
      default:    return $urandom();
    endcase
  endfunction

  initial begin
    op_e op;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed items: extremes, every operation and the special cases.
    send_item(OP_NORM, 32'd6, -32'sd4, 32'd0, 32'd0);      // sign moves up, b ignored
    send_item(OP_NORM, 32'h8000_0000, 32'd1, 32'd5, 32'd7); // most negative fits
    send_item(OP_NORM, 32'h8000_0000, 32'hffff_ffff, 0, 0); // becomes +2^31: overflow
    send_item(OP_NORM, 32'd5, 32'd0, 32'd1, 32'd1);         // zero denominator
    send_item(OP_NORM, 32'd0, 32'h8000_0000, 0, 0);         // zero result
    send_item(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    send_item(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd0);          // b denominator zero
    send_item(OP_ADD, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
    send_item(OP_ADD, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
    send_item(OP_ADD, 32'd1, 32'd2, -32'sd1, 32'd2);         // cancels to zero
    send_item(OP_SUB, 32'd3, 32'd4, 32'd1, 32'd4);
    send_item(OP_SUB, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
    send_item(OP_SUB, 32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_fffe);
    send_item(OP_SUB, 32'd7, 32'd3, 32'd7, 32'd3);
    send_item(OP_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
    send_item(OP_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_item(OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_item(OP_MUL, 32'd0, 32'd5, 32'd3, 32'd0);
    send_item(OP_MUL, 32'h0001_0000, 32'd1, 32'h0000_8000, 32'd1);
    send_item(OP_MUL, 32'h5555_5555, 32'haaaa_aaaa, 32'h3333_3333, 32'hcccc_cccc);
    idle_burst();

    // Let the block drain completely once before the random part.
    while (pending != 0) @(negedge clk_i);

    for (int i = 0; i < N_RANDOM; i++) begin
      op = op_e'($urandom_range(3, 0));
      send_item(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
      // Random gaps except in the last stretch of the run.
      if (i < N_RANDOM - 150 && $urandom_range(3, 0) == 0) idle_burst();
      if (i == N_RANDOM / 2) begin
        // Stop sending so the same item is not taken again while draining.
        @(negedge clk_i);
        start_i <= 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    start_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Sent %0d items (%0d ok, %0d overflow, %0d zero denominator results).",
             n_sent, n_ok, n_ovf, n_zden);
    $display("Directed extremes plus random add/sub/mul/normalize, %0d mismatches.", errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
